>>> design/cpor_pkg.sv
// ---------------------------------------------------------------------------
// cpor_pkg: shared types and constants for circle pair overlap resolve
// Holds the payload structs of both queue sides and the fixed-point widths.
// ---------------------------------------------------------------------------
`default_nettype none
package cpor_pkg;

  localparam int COORD_W  = 24;  // signed Q16.8 coordinate
  localparam int RAD_W    = 16;  // unsigned Q8.8 radius and threshold
  localparam int NEAR_W   = 17;  // |dx|, |dy| below 2^17 or the pair is far apart
  localparam int ROOT_W   = 18;  // floor(sqrt(dx^2 + dy^2))
  localparam int SQ_W     = 2 * ROOT_W;
  localparam int PROD_W   = 2 * NEAR_W;
  localparam int QUO_W    = 16;  // shift never exceeds ov/2
  localparam int DIFF_W   = COORD_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic        [RAD_W-1:0]   first_radius;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic        [RAD_W-1:0]   second_radius;
  } pair_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_first_x;
    logic signed [COORD_W-1:0] new_first_y;
    logic signed [COORD_W-1:0] new_second_x;
    logic signed [COORD_W-1:0] new_second_y;
    logic                      resolved;
  } result_t;

  // classified pair as it leaves the front end
  typedef struct packed {
    pair_t             pair;
    logic              act;
    logic              dyneg;
    logic [NEAR_W-1:0] rsum;
    logic [NEAR_W-1:0] dx;
    logic [NEAR_W-1:0] ady;
  } cls_t;

endpackage
`default_nettype wire

>>> design/circle_pair_overlap_resolve_core.sv
// ---------------------------------------------------------------------------
// circle_pair_overlap_resolve_core: push apart one overlapping circle pair
// Front end classifies and queues pairs; back end resolves them in a pipeline.
// ---------------------------------------------------------------------------
//   channel   handshake            payload
//   pair in   push / full          pair    (cpor_pkg::pair_t)
//   result    empty / pop          result  (cpor_pkg::result_t)
//   config    cfg_valid/cfg_ready  cfg_data (overlap threshold, Q8.8)
//
// One pair per cycle sustained while results are popped. The back pipeline
// holds 2 square stages, 18 root stages, 1 overlap stage, 17 divide
// stages and the result register; pairs may also wait in the front queue.
// Reset clears the queue, the pipeline valids and the threshold (to 0).
// A held result stalls the whole back pipeline; the front queue keeps
// taking pairs until it fills.
`default_nettype none
module circle_pair_overlap_resolve_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire cpor_pkg::pair_t            pair,
  output logic                            empty,
  input  wire logic                       pop,
  output cpor_pkg::result_t               result,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [cpor_pkg::RAD_W-1:0] cfg_data
);

  logic [cpor_pkg::RAD_W-1:0] threshold;
  logic                       q_valid;
  logic                       q_take;
  cpor_pkg::cls_t             q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  cpor_front #(
    .DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .pair    (pair),
    .q_valid (q_valid),
    .q_take  (q_take),
    .q_item  (q_item)
  );

  cpor_back u_back (
    .clk       (clk),
    .rst       (rst),
    .threshold (threshold),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_item    (q_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
`default_nettype wire

>>> design/cpor_front.sv
// ---------------------------------------------------------------------------
// cpor_front: accept and classify circle pairs
// Forms dx, |dy|, the radius sum and the act flag, and queues the result.
// ---------------------------------------------------------------------------
`default_nettype none
module cpor_front #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  output logic                full,
  input  wire cpor_pkg::pair_t pair,
  output logic                q_valid,
  input  wire logic           q_take,
  output cpor_pkg::cls_t      q_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cpor_pkg::cls_t           mem [DEPTH];
  logic [PW-1:0]            wr_ptr;
  logic [PW-1:0]            rd_ptr;
  logic [CW-1:0]            count;
  logic                     wr_en;
  logic                     rd_en;
  cpor_pkg::cls_t           cls;
  logic signed [cpor_pkg::DIFF_W-1:0] dx;
  logic signed [cpor_pkg::DIFF_W-1:0] dy;
  logic signed [cpor_pkg::DIFF_W-1:0] ady;
  logic                     near;

  localparam logic signed [cpor_pkg::DIFF_W-1:0] FAR_LIM =
    cpor_pkg::DIFF_W'(1) <<< cpor_pkg::NEAR_W;

  assign dx  = cpor_pkg::DIFF_W'(pair.second_x) - cpor_pkg::DIFF_W'(pair.first_x);
  assign dy  = cpor_pkg::DIFF_W'(pair.second_y) - cpor_pkg::DIFF_W'(pair.first_y);
  assign ady = dy[cpor_pkg::DIFF_W-1] ? -dy : dy;
  assign near = (dx < FAR_LIM) && (ady < FAR_LIM);

  always_comb begin
    cls.pair  = pair;
    cls.act   = (pair.first_x < pair.second_x) && near;
    cls.dyneg = dy[cpor_pkg::DIFF_W-1];
    cls.rsum  = cpor_pkg::NEAR_W'(pair.first_radius) + cpor_pkg::NEAR_W'(pair.second_radius);
    cls.dx    = dx[cpor_pkg::NEAR_W-1:0];
    cls.ady   = ady[cpor_pkg::NEAR_W-1:0];
  end

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];
  assign wr_en   = push && !full;
  assign rd_en   = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(wr_en) - CW'(rd_en);
    end
  end

endmodule
`default_nettype wire

>>> design/cpor_back.sv
// ---------------------------------------------------------------------------
// cpor_back: distance, overlap and push-apart pipeline
// Squares, a bit-per-stage square root, two bit-per-stage dividers and a
// saturating update, ending in the result register.
// ---------------------------------------------------------------------------
`default_nettype none
module cpor_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [cpor_pkg::RAD_W-1:0]  threshold,
  input  wire logic                        q_valid,
  output logic                             q_take,
  input  wire cpor_pkg::cls_t              q_item,
  output logic                             empty,
  input  wire logic                        pop,
  output cpor_pkg::result_t                result
);

  localparam int NW   = cpor_pkg::NEAR_W;
  localparam int RW   = cpor_pkg::ROOT_W;
  localparam int SW   = cpor_pkg::SQ_W;
  localparam int PRW  = cpor_pkg::PROD_W;
  localparam int QW   = cpor_pkg::QUO_W;
  localparam int CWD  = cpor_pkg::COORD_W;
  localparam int REMW = RW + 2;       // square root remainder
  localparam int DENW = RW + 1;       // 2*d
  localparam int HIW  = PRW - QW;     // dividend bits above the quotient

  logic adv;
  logic out_valid;

  assign adv    = !out_valid || pop;
  assign q_take = adv && q_valid;
  assign empty  = !out_valid;

  // squares
  cpor_pkg::cls_t  c1;
  logic            v1;
  logic [PRW-1:0]  mxx, myy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1  <= q_item;
      mxx <= q_item.dx * q_item.dx;
      myy <= q_item.ady * q_item.ady;
    end
  end

  // square root, one result bit per stage
  cpor_pkg::cls_t  sc   [RW+1];
  logic [SW-1:0]   srad [RW+1];
  logic [REMW-1:0] srem [RW+1];
  logic [RW-1:0]   sroot[RW+1];
  logic            sv   [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc[0]    <= c1;
      srad[0]  <= SW'(mxx) + SW'(myy);
      srem[0]  <= '0;
      sroot[0] <= '0;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [REMW+1:0] rem_sh;
    logic [REMW+1:0] trial;
    logic            ge;

    assign rem_sh = {srem[k], srad[k][SW-1-2*k -: 2]};
    assign trial  = {2'b00, sroot[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sc[k+1]    <= sc[k];
        srad[k+1]  <= srad[k];
        srem[k+1]  <= ge ? REMW'(rem_sh - trial) : REMW'(rem_sh);
        sroot[k+1] <= {sroot[k][RW-2:0], ge};
      end
    end
  end

  // overlap and threshold test
  cpor_pkg::cls_t     c3;
  logic               v3;
  logic               ok3;
  logic [NW-1:0]      ov3;
  logic [RW-1:0]      d3;
  logic signed [RW:0] ov_full;

  assign ov_full = $signed({2'b00, sc[RW].rsum}) - $signed({1'b0, sroot[RW]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= sv[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3  <= sc[RW];
      d3  <= sroot[RW];
      ov3 <= ov_full[NW-1:0];
      ok3 <= sc[RW].act && (sroot[RW] != '0) &&
             (ov_full > $signed({3'b000, threshold}));
    end
  end

  // products ov*dx and ov*|dy|, divided by 2d one quotient bit per stage
  cpor_pkg::cls_t  dc  [QW+1];
  logic            dv  [QW+1];
  logic            dok [QW+1];
  logic [DENW-1:0] dden[QW+1];
  logic [DENW-1:0] xrem[QW+1];
  logic [DENW-1:0] yrem[QW+1];
  logic [QW-1:0]   xlo [QW+1];
  logic [QW-1:0]   ylo [QW+1];
  logic [QW-1:0]   xq  [QW+1];
  logic [QW-1:0]   yq  [QW+1];
  logic [PRW-1:0]  px, py;

  assign px = ov3 * c3.dx;
  assign py = ov3 * c3.ady;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dc[0]   <= c3;
      dok[0]  <= ok3;
      dden[0] <= {d3, 1'b0};
      xrem[0] <= DENW'(px[PRW-1:QW]);
      yrem[0] <= DENW'(py[PRW-1:QW]);
      xlo[0]  <= px[QW-1:0];
      ylo[0]  <= py[QW-1:0];
      xq[0]   <= '0;
      yq[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DENW:0] xs_sh, ys_sh;
    logic          xge, yge;

    assign xs_sh = {xrem[j], xlo[j][QW-1]};
    assign ys_sh = {yrem[j], ylo[j][QW-1]};
    assign xge   = (xs_sh >= {1'b0, dden[j]});
    assign yge   = (ys_sh >= {1'b0, dden[j]});

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (adv) begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dc[j+1]   <= dc[j];
        dok[j+1]  <= dok[j];
        dden[j+1] <= dden[j];
        xrem[j+1] <= xge ? DENW'(xs_sh - {1'b0, dden[j]}) : DENW'(xs_sh);
        yrem[j+1] <= yge ? DENW'(ys_sh - {1'b0, dden[j]}) : DENW'(ys_sh);
        xlo[j+1]  <= {xlo[j][QW-2:0], 1'b0};
        ylo[j+1]  <= {ylo[j][QW-2:0], 1'b0};
        xq[j+1]   <= {xq[j][QW-2:0], xge};
        yq[j+1]   <= {yq[j][QW-2:0], yge};
      end
    end
  end

  // apply the shifts and clamp to the coordinate range
  function automatic logic signed [CWD-1:0] sat(input logic signed [CWD:0] v);
    logic signed [CWD-1:0] r;
    if (v[CWD] != v[CWD-1]) begin
      r = v[CWD] ? {1'b1, {(CWD-1){1'b0}}} : {1'b0, {(CWD-1){1'b1}}};
    end else begin
      r = v[CWD-1:0];
    end
    return r;
  endfunction

  cpor_pkg::pair_t        fp;
  logic signed [CWD:0]    xs, ys;
  logic signed [CWD:0]    ymag;
  cpor_pkg::result_t      res_next;

  assign fp   = dc[QW].pair;
  assign xs   = dok[QW] ? $signed((CWD+1)'(xq[QW])) : '0;
  assign ymag = dok[QW] ? $signed((CWD+1)'(yq[QW])) : '0;
  assign ys   = dc[QW].dyneg ? -ymag : ymag;

  always_comb begin
    res_next.new_first_x  = sat((CWD+1)'(fp.first_x)  - xs);
    res_next.new_first_y  = sat((CWD+1)'(fp.first_y)  - ys);
    res_next.new_second_x = sat((CWD+1)'(fp.second_x) + xs);
    res_next.new_second_y = sat((CWD+1)'(fp.second_y) + ys);
    res_next.resolved     = dok[QW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire
